// ===== src/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Result codes, the result record and reset constants that the parser and
// the top level share.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

  localparam int unsigned LenW = 64;

  localparam logic [LenW-1:0] MaxLenReset = 64'd67108864;

  typedef enum logic [1:0] {
    KindData  = 2'd0,
    KindEmpty = 2'd1,
    KindError = 2'd2
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== src/wsd_parser.sv =====
// ----------------------------------------------------------------------------
// WebSocket deframer header and payload parser
// Holds the frame parse state, consumes one byte per transfer and forms the
// result that belongs to that byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      acc_i,
  input  wire logic [7:0]                byte_i,
  input  wire logic [wsd_pkg::LenW-1:0]  max_len_i,
  output wsd_pkg::result_t               res_o
);

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExt16   = 3'd2,
    PhExt64   = 3'd3,
    PhMask    = 3'd4,
    PhPayload = 3'd5,
    PhHalt    = 3'd6
  } phase_e;

  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;
  localparam logic [2:0] Ext16Last = 3'd1;
  localparam logic [2:0] Ext64Last = 3'd7;
  localparam logic [2:0] MaskLast  = 3'd3;

  phase_e                    phase_q, phase_d;
  logic [3:0]                opc_q, opc_d;
  logic                      mask_q, mask_d;
  logic [wsd_pkg::LenW-1:0]  len_q, len_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [31:0]               key_q, key_d;
  logic [1:0]                lane_q, lane_d;
  logic                      len_done;
  logic                      key_done;
  logic                      last;
  logic [7:0]                key_byte;
  wsd_pkg::result_t          res;

  always_comb begin
    phase_d  = phase_q;
    opc_d    = opc_q;
    mask_d   = mask_q;
    len_d    = len_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    lane_d   = lane_q;
    len_done = 1'b0;
    key_done = 1'b0;
    last     = (len_q <= 64'd1);
    key_byte = 8'h00;
    res      = '0;
    res.opcode = opc_q;

    case (lane_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase

    if (acc_i) begin
      unique case (phase_q)
        PhHdr0: begin
          opc_d   = byte_i[3:0];
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          mask_d = byte_i[7];
          key_d  = '0;
          cnt_d  = '0;
          len_d  = {{(wsd_pkg::LenW-7){1'b0}}, byte_i[6:0]};
          if (byte_i[6:0] == LenCode16) begin
            len_d   = '0;
            phase_d = PhExt16;
          end else if (byte_i[6:0] == LenCode64) begin
            len_d   = '0;
            phase_d = PhExt64;
          end else begin
            len_done = 1'b1;
          end
        end
        PhExt16, PhExt64: begin
          len_d = {len_q[wsd_pkg::LenW-9:0], byte_i};
          if (cnt_q >= ((phase_q == PhExt16) ? Ext16Last : Ext64Last)) begin
            cnt_d    = '0;
            len_done = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhMask: begin
          key_d = {key_q[23:0], byte_i};
          if (cnt_q >= MaskLast) begin
            cnt_d    = '0;
            key_done = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PhPayload: begin
          lane_d = lane_q + 2'd1;
          if (len_q != '0) begin
            len_d = len_q - 64'd1;
          end
          if (last) begin
            phase_d = PhHdr0;
          end
          res.valid = 1'b1;
          res.kind  = wsd_pkg::KindData;
          res.data  = byte_i ^ key_byte;
          res.last  = last;
        end
        default: begin
          phase_d = PhHalt;
        end
      endcase

      if (len_done && mask_d) begin
        cnt_d   = '0;
        phase_d = PhMask;
      end else if (len_done || key_done) begin
        if (len_d > max_len_i) begin
          phase_d   = PhHalt;
          res.valid = 1'b1;
          res.kind  = wsd_pkg::KindError;
        end else if (len_d == '0) begin
          phase_d   = PhHdr0;
          res.valid = 1'b1;
          res.kind  = wsd_pkg::KindEmpty;
          res.last  = 1'b1;
        end else begin
          lane_d  = '0;
          phase_d = PhPayload;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr0;
      opc_q   <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      cnt_q   <= '0;
      key_q   <= '0;
      lane_q  <= '0;
    end else begin
      phase_q <= phase_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      key_q   <= key_d;
      lane_q  <= lane_d;
    end
  end

  assign res_o = res;

  a_halt_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHalt |=> phase_q == PhHalt)
    else $error("parser left the halted phase");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> len_q != '0)
    else $error("payload phase with no bytes remaining");

endmodule

`default_nettype wire

// ===== src/websocket_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// WebSocket frame deframer core
// Parses a received WebSocket frame byte stream and emits unmasked payload
// bytes, empty-frame marks and an oversize error.
//
//   Channel   Direction  Handshake                  Payload
//   in        input      in_valid_i / in_stall_o    in_byte_i
//   out       output     out_valid_o / out_stall_i  result_kind_o, data_byte_o,
//                                                    frame_opcode_o, last_of_frame_o
//   cfg       input      cfg_we_i                   cfg_wdata_i (max_payload_len)
//
// One byte is taken per cycle when not stalled; its result appears in the
// output register on the following cycle. The parse logic sits between the byte
// input and that register, so the rate is set by the single output register alone.
// The input is stalled only while a result is held and the output is stalled.
// Reset returns the parser to the first header byte and the limit to 64 MiB.
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       data_byte_o,
  output logic [3:0]       frame_opcode_o,
  output logic             last_of_frame_o
);

  logic [wsd_pkg::LenW-1:0] max_len_q;
  logic                     in_acc;
  wsd_pkg::result_t         res;
  logic                     out_valid_q;
  wsd_pkg::kind_e           kind_q;
  logic [7:0]               data_q;
  logic [3:0]               opc_q;
  logic                     last_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= wsd_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .byte_i    (in_byte_i),
    .max_len_i (max_len_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= res.valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= res.kind;
      data_q <= res.data;
      opc_q  <= res.opcode;
      last_q <= res.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = kind_q;
  assign data_byte_o     = data_q;
  assign frame_opcode_o  = opc_q;
  assign last_of_frame_o = last_q;

  a_error_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == wsd_pkg::KindError |-> !last_of_frame_o)
    else $error("error result marked as last of frame");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == wsd_pkg::KindEmpty
      |-> last_of_frame_o && data_byte_o == 8'h00)
    else $error("empty-frame result malformed");

  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && result_kind_o == wsd_pkg::KindError |=> !out_valid_o)
    else $error("result after an error transfer");

endmodule

`default_nettype wire
